/* rtl/xpf_pkg.sv */
// Shared constants, types and helpers of the XOR parity FEC encoder.
`timescale 1ns / 1ps

package xpf_pkg;

    // Store geometry and field widths
    localparam int MAX_WORDS   = 64;
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int POS_W       = $clog2(MAX_WORDS + 1);
    localparam int LEN_W       = $clog2(8 * MAX_WORDS + 1);
    localparam int CNT_W       = 8;
    localparam int GN_W        = 16;
    localparam int NB_W        = 4;
    localparam int DW          = 64;

    localparam logic [CNT_W-1:0] MIN_GROUP  = 8'd2;
    localparam logic [NB_W-1:0]  WORD_BYTES = 4'd8;

    // Item kinds carried in tuser
    typedef enum logic {
        OP_DATA  = 1'b0,
        OP_FLUSH = 1'b1
    } t_op;

    // Parameters of one parity packet, handed to the readout sequencer
    typedef struct packed {
        logic [GN_W-1:0]  group;
        logic [CNT_W-1:0] hdr;
        logic [LEN_W-1:0] longest;
    } t_emit_start;

    // Read request into the parity store
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_rd_req;

    // One parity result item
    typedef struct packed {
        logic [GN_W-1:0]  group;
        logic [CNT_W-1:0] hdr;
        logic [DW-1:0]    word;
        logic [NB_W-1:0]  nb;
        logic             last;
    } t_out_item;

    // Keep the low nb bytes of a word
    function automatic logic [DW-1:0] byte_mask(input logic [NB_W-1:0] nb);
        logic [DW-1:0] m;
        m = '0;
        for (int b = 0; b < DW / 8; b++) begin
            if (NB_W'(b) < nb) begin
                m[8*b +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

/* rtl/xpf_store.sv */
// Parity store: synchronous memory with per-entry written bits.
`timescale 1ns / 1ps

module xpf_store
    import xpf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DW-1:0]     i_wr_data,
    input  t_rd_req           i_rd_req,
    input  logic              i_clear,
    output logic [DW-1:0]     o_rd_data,
    output logic              o_rd_valid
);

    logic [DW-1:0]          mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] r_written;
    logic [DW-1:0]          r_rd_data;
    logic                   r_rd_valid;

    // Write and registered read of the array
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_req.en) begin
            r_rd_data <= mem[i_rd_req.addr];
        end
    end

    // Track written entries; clear the whole group at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written  <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_rd_req.en) begin
                r_rd_valid <= r_written[i_rd_req.addr];
            end
            if (i_clear) begin
                r_written <= '0;
            end
            if (i_wr_en) begin
                r_written[i_wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_rd_valid = r_rd_valid;

endmodule

/* rtl/xpf_emit.sv */
// Parity packet readout: walks the store and queues result items.
`timescale 1ns / 1ps

module xpf_emit
    import xpf_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  t_emit_start   i_start_info,
    output logic          o_busy,
    output t_rd_req       o_rd_req,
    input  logic [DW-1:0] i_rd_data,
    input  logic          i_rd_valid,
    output logic          o_clear,
    output t_out_item     o_item,
    output logic          o_item_valid,
    input  logic          i_item_ready
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_ISSUE = 2'b10
    } t_emit_state;

    t_emit_state       r_state, n_state;
    logic [ADDR_W-1:0] r_k, n_k;
    logic [ADDR_W-1:0] r_last_k, n_last_k;
    logic [LEN_W-1:0]  r_longest, n_longest;
    logic [GN_W-1:0]   r_group, n_group;
    logic [CNT_W-1:0]  r_hdr, n_hdr;

    // In-flight read metadata
    logic              r_p_valid;
    logic [NB_W-1:0]   r_p_nb;
    logic              r_p_last;
    logic [GN_W-1:0]   r_p_group;
    logic [CNT_W-1:0]  r_p_hdr;

    // Two-entry output queue
    t_out_item         r_fifo [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;

    logic              pop;
    logic              issue;
    logic [2:0]        occ;
    logic [LEN_W:0]    len_round;
    logic [LEN_W-3:0]  nwords;
    logic [LEN_W-1:0]  left;
    logic [NB_W-1:0]   nb;
    t_out_item         ret_item;

    assign pop   = (r_count != 2'd0) && i_item_ready;
    assign occ   = 3'(r_count) + 3'(r_p_valid);
    assign issue = (r_state == ST_ISSUE) && ((occ < 3'd2) || ((occ == 3'd2) && pop));

    // Word count of the packet, clamped to the store
    always_comb begin
        len_round = (LEN_W + 1)'(i_start_info.longest) + (LEN_W + 1)'(7);
        nwords    = len_round[LEN_W:3];
        if (nwords > (LEN_W - 2)'(MAX_WORDS)) begin
            nwords = (LEN_W - 2)'(MAX_WORDS);
        end
    end

    // Bytes of the word now being read
    always_comb begin
        left = r_longest - LEN_W'({r_k, 3'b000});
        nb   = (left > LEN_W'(WORD_BYTES)) ? WORD_BYTES : left[NB_W-1:0];
    end

    // Sequencer: one read per free queue slot
    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        n_last_k  = r_last_k;
        n_longest = r_longest;
        n_group   = r_group;
        n_hdr     = r_hdr;
        o_clear   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state   = ST_ISSUE;
                    n_k       = '0;
                    n_last_k  = (nwords == '0) ? '0 : ADDR_W'(nwords - 1'b1);
                    n_longest = i_start_info.longest;
                    n_group   = i_start_info.group;
                    n_hdr     = i_start_info.hdr;
                end
            end
            ST_ISSUE: begin
                if (issue) begin
                    if (r_k == r_last_k) begin
                        n_state = ST_IDLE;
                        o_clear = 1'b1;
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_rd_req.en   = issue;
    assign o_rd_req.addr = r_k;
    assign o_busy        = (r_state == ST_ISSUE);

    // Build the item from returned data
    always_comb begin
        ret_item.group = r_p_group;
        ret_item.hdr   = r_p_hdr;
        ret_item.word  = i_rd_valid ? (i_rd_data & byte_mask(r_p_nb)) : '0;
        ret_item.nb    = r_p_nb;
        ret_item.last  = r_p_last;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_p_valid <= 1'b0;
            r_wr_ptr  <= 1'b0;
            r_rd_ptr  <= 1'b0;
            r_count   <= 2'd0;
        end else begin
            r_state   <= n_state;
            r_p_valid <= issue;
            if (r_p_valid) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(r_p_valid) - 2'(pop);
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_k       <= n_k;
        r_last_k  <= n_last_k;
        r_longest <= n_longest;
        r_group   <= n_group;
        r_hdr     <= n_hdr;
        if (issue) begin
            r_p_nb    <= nb;
            r_p_last  <= (r_k == r_last_k);
            r_p_group <= r_group;
            r_p_hdr   <= r_hdr;
        end
        if (r_p_valid) begin
            r_fifo[r_wr_ptr] <= ret_item;
        end
    end

    assign o_item       = r_fifo[r_rd_ptr];
    assign o_item_valid = (r_count != 2'd0);

    // Queue never overflows
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("output queue overfilled");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_valid |-> ((r_count < 2'd2) || pop))
        else $error("read returned with no queue slot");

    a_clear_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_clear |-> (r_state == ST_ISSUE) && issue)
        else $error("store cleared outside readout");

endmodule

/* rtl/xor_parity_fec_encoder_top.sv */
// A data word is merged into the store in the cycle after acceptance.
// Parity output: first word goes via stage 1, sequencer, store read and output queue.
// Throughput: one item per cycle in outside emission; parity words leave at one per cycle
// while the output is ready. Emission holds off input from the trigger's stage 1 until
// the readout has issued its last store read; output stalls extend the hold.
// Reset (synchronous, active low): counters, written bits cleared; memory not.
`timescale 1ns / 1ps

module xor_parity_fec_encoder_top
    import xpf_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Configuration: data packets per parity group
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [7:0]   i_cfg_data,
    // Input stream
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [71:0]  i_s_axis_tdata,   // data_word[63:0], word_bytes[67:64], zero
    input  logic         i_s_axis_tlast,   // end_of_packet
    input  logic         i_s_axis_tuser,   // operation
    // Output stream
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [103:0] o_m_axis_tdata,   // group_number[15:0], hdr_size[23:16],
                                           // parity_index[31:24], parity_word[95:32],
                                           // parity_bytes[99:96], zero
    output logic         o_m_axis_tlast    // final_word
);

    logic [CNT_W-1:0]  r_grp_pkts;
    logic [POS_W-1:0]  r_pos;
    logic [CNT_W-1:0]  r_pkts;
    logic [LEN_W-1:0]  r_longest;
    logic [GN_W-1:0]   r_group;

    // Stage 1 of the read-modify-write
    logic              r_s1_valid;
    logic              r_s1_wr;
    logic [ADDR_W-1:0] r_s1_addr;
    logic [DW-1:0]     r_s1_data;
    logic              r_s1_emit;
    t_emit_start       r_s1_start;
    logic              r_fwd;
    logic [DW-1:0]     r_fwd_data;

    logic              accept;
    logic              is_flush;
    logic [NB_W-1:0]   nb;
    logic              in_store;
    logic [LEN_W-1:0]  extent;
    logic [LEN_W-1:0]  n_longest;
    logic [CNT_W-1:0]  pkt_next;
    logic [CNT_W-1:0]  eff;
    logic              trigger;
    logic [CNT_W-1:0]  hdr;
    t_rd_req           ing_rd;
    t_rd_req           emit_rd;
    t_rd_req           rd_req;
    logic [DW-1:0]     rd_data;
    logic              rd_valid;
    logic [DW-1:0]     old_word;
    logic [DW-1:0]     wr_data;
    logic              emit_busy;
    logic              clear;
    t_out_item         item;

    assign o_cfg_ready = 1'b1;

    // Take the packets-per-group register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_pkts <= MIN_GROUP;
        end else if (i_cfg_valid) begin
            r_grp_pkts <= i_cfg_data;
        end
    end

    assign o_s_axis_tready = !emit_busy && !(r_s1_valid && r_s1_emit);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign is_flush        = (t_op'(i_s_axis_tuser) == OP_FLUSH);

    // Decode the incoming item
    always_comb begin
        nb = (i_s_axis_tdata[67:64] > WORD_BYTES) ? WORD_BYTES : i_s_axis_tdata[67:64];
        in_store  = (r_pos < POS_W'(MAX_WORDS));
        extent    = LEN_W'({r_pos, 3'b000}) + LEN_W'(nb);
        n_longest = r_longest;
        if (in_store && (nb != '0) && (extent > r_longest)) begin
            n_longest = extent;
        end
        pkt_next = r_pkts + 1'b1;
        eff      = (r_grp_pkts < MIN_GROUP) ? MIN_GROUP : r_grp_pkts;
        if (is_flush) begin
            trigger = (r_pkts != '0);
            hdr     = r_pkts;
        end else begin
            trigger = i_s_axis_tlast && (pkt_next >= eff);
            hdr     = eff;
        end
    end

    assign ing_rd.en   = accept && !is_flush && in_store;
    assign ing_rd.addr = ADDR_W'(r_pos);
    assign rd_req      = emit_busy ? emit_rd : ing_rd;

    // Group bookkeeping at acceptance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_pkts     <= '0;
            r_longest  <= '0;
            r_group    <= '0;
            r_s1_valid <= 1'b0;
            r_s1_wr    <= 1'b0;
            r_s1_emit  <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            r_s1_wr    <= ing_rd.en;
            r_s1_emit  <= accept && trigger;
            r_fwd      <= ing_rd.en && r_s1_valid && r_s1_wr && (r_s1_addr == ing_rd.addr);
            if (accept) begin
                if (trigger) begin
                    r_pos     <= '0;
                    r_pkts    <= '0;
                    r_longest <= '0;
                    r_group   <= r_group + 1'b1;
                end else if (!is_flush) begin
                    r_longest <= n_longest;
                    if (i_s_axis_tlast) begin
                        r_pos  <= '0;
                        r_pkts <= pkt_next;
                    end else if (in_store) begin
                        r_pos <= r_pos + 1'b1;
                    end
                end
            end
        end
    end

    // Stage 1 payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_addr          <= ing_rd.addr;
            r_s1_data          <= i_s_axis_tdata[DW-1:0] & byte_mask(nb);
            r_s1_start.group   <= r_group;
            r_s1_start.hdr     <= hdr;
            r_s1_start.longest <= is_flush ? r_longest : n_longest;
        end
        r_fwd_data <= wr_data;
    end

    // Merge the word into its store entry, forwarding a write to the same entry
    always_comb begin
        if (r_fwd) begin
            old_word = r_fwd_data;
        end else if (rd_valid) begin
            old_word = rd_data;
        end else begin
            old_word = '0;
        end
        wr_data = old_word ^ r_s1_data;
    end

    xpf_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (r_s1_valid && r_s1_wr),
        .i_wr_addr  (r_s1_addr),
        .i_wr_data  (wr_data),
        .i_rd_req   (rd_req),
        .i_clear    (clear),
        .o_rd_data  (rd_data),
        .o_rd_valid (rd_valid)
    );

    xpf_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (r_s1_valid && r_s1_emit),
        .i_start_info (r_s1_start),
        .o_busy       (emit_busy),
        .o_rd_req     (emit_rd),
        .i_rd_data    (rd_data),
        .i_rd_valid   (rd_valid),
        .o_clear      (clear),
        .o_item       (item),
        .o_item_valid (o_m_axis_tvalid),
        .i_item_ready (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {4'b0000, item.nb, item.word, item.hdr, item.hdr, item.group};
    assign o_m_axis_tlast = item.last;

    // Input is held off while the store is being read out
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> !emit_busy)
        else $error("item accepted during parity readout");

    a_emit_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_emit) |=> emit_busy)
        else $error("parity readout did not start");

    a_fwd_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_s1_valid && r_s1_wr && $past(r_s1_valid && r_s1_wr))
        else $error("forward without a back-to-back store write");

    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_wr && !r_s1_emit) |-> !emit_busy)
        else $error("store write during readout");

endmodule

/* bench/testbench.sv */
// Self-checking testbench for the XOR parity FEC encoder: directed table, random packets.
`timescale 1ns / 1ps

module testbench;
    import xpf_pkg::*;

    localparam int SETTLE_CYCLES = 12;
    localparam int LONG_HOLD     = 300;
    localparam int STALL_LIMIT   = 2000;

    // One parity word as it leaves the block
    typedef struct packed {
        logic [15:0] gnum;
        logic [7:0]  gsize;
        logic [7:0]  pindex;
        logic [63:0] pword;
        logic [3:0]  pbytes;
        logic        plast;
    } t_parity_word;

    // One row of the directed table; a typed row carries its own expectation
    typedef struct {
        t_op          op;
        logic [63:0]  data;
        logic [3:0]   nb;
        logic         eop;
        bit           typed;
        bit           has_word;
        t_parity_word word;
    } t_stim_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [7:0]   i_cfg_data = '0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [71:0]  i_s_axis_tdata = '0;    // data_word[63:0], word_bytes[67:64], zero
    logic         i_s_axis_tlast = 1'b0;  // end_of_packet
    logic         i_s_axis_tuser = 1'b0;  // operation
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [103:0] o_m_axis_tdata;         // group_number[15:0], hdr_size[23:16],
                                          // parity_index[31:24], parity_word[95:32],
                                          // parity_bytes[99:96], zero
    logic         o_m_axis_tlast;         // final_word

    // Expectation that travels with the item on the bus (directed rows only)
    bit           row_typed = 1'b0;
    bit           row_has_word = 1'b0;
    t_parity_word row_word = '0;

    // Encoder state as predicted
    logic [63:0]  store_word [64];
    bit           store_valid [64];
    int unsigned  longest_extent = 0;
    int unsigned  word_slot = 0;
    logic [7:0]   packets_pending = '0;
    logic [15:0]  group_no = '0;
    logic [7:0]   grp_pkts_reg = 8'd2;

    t_parity_word fresh_words [$];
    t_parity_word parity_expected [$];

    int           mismatch_count = 0;
    int           idle_cycles = 0;
    int           burst_left = 0;
    bit           hold_request = 1'b0;

    t_stim_row    directed_rows [19];

    xor_parity_fec_encoder_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        foreach (store_valid[k]) store_valid[k] = 1'b0;
    end

    // Keep the low n bytes of a word
    function automatic logic [63:0] low_bytes(input int unsigned n);
        if (n >= 8) return '1;
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Emit the parity packet of the group, then start a fresh group
    function automatic void close_parity_group(input logic [7:0] hdr);
        int unsigned  n_words;
        int unsigned  left;
        int unsigned  nb;
        t_parity_word w;
        n_words = (longest_extent + 7) / 8;
        if (n_words > MAX_WORDS) n_words = MAX_WORDS;
        w.gnum   = group_no;
        w.gsize  = hdr;
        w.pindex = hdr;
        if (n_words == 0) begin
            w.pword  = '0;
            w.pbytes = '0;
            w.plast  = 1'b1;
            fresh_words = {fresh_words, w};
        end
        for (int k = 0; k < n_words; k++) begin
            left     = longest_extent - 8 * k;
            nb       = (left > 8) ? 8 : left;
            w.pword  = store_valid[k] ? (store_word[k] & low_bytes(nb)) : '0;
            w.pbytes = 4'(nb);
            w.plast  = (k + 1 == n_words);
            fresh_words = {fresh_words, w};
        end
        group_no        = group_no + 16'd1;
        packets_pending = '0;
        longest_extent  = 0;
        word_slot       = 0;
        foreach (store_valid[k]) store_valid[k] = 1'b0;
    endfunction

    // Work out the parity words that one accepted item releases
    function automatic void predict_parity_words(input t_op op, input logic [63:0] data,
                                                 input logic [3:0] nb_raw, input logic eop);
        int unsigned nb;
        logic [63:0] v;
        logic [7:0]  eff_size;
        if (op == OP_FLUSH) begin
            if (packets_pending != 0) close_parity_group(packets_pending);
            return;
        end
        nb = (nb_raw > 8) ? 8 : nb_raw;
        // Words past the store are dropped; only their end mark counts
        if (word_slot < MAX_WORDS) begin
            v = data & low_bytes(nb);
            store_word[word_slot]  = store_valid[word_slot] ? (store_word[word_slot] ^ v) : v;
            store_valid[word_slot] = 1'b1;
            if (nb > 0 && 8 * word_slot + nb > longest_extent)
                longest_extent = 8 * word_slot + nb;
            word_slot++;
        end
        if (eop) begin
            word_slot       = 0;
            packets_pending = packets_pending + 8'd1;
            eff_size        = (grp_pkts_reg < MIN_GROUP) ? MIN_GROUP : grp_pkts_reg;
            if (packets_pending >= eff_size) close_parity_group(eff_size);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, want);
    endtask

    // Compare one accepted parity word with the oldest expectation
    task automatic check_parity_word();
        t_parity_word got;
        t_parity_word want;
        got.gnum   = o_m_axis_tdata[15:0];
        got.gsize  = o_m_axis_tdata[23:16];
        got.pindex = o_m_axis_tdata[31:24];
        got.pword  = o_m_axis_tdata[95:32];
        got.pbytes = o_m_axis_tdata[99:96];
        got.plast  = o_m_axis_tlast;
        if (parity_expected.size() == 0) begin
            report_mismatch("unexpected parity word", got.pword, '0);
            return;
        end
        want = parity_expected.pop_front();
        if (got.gnum != want.gnum)     report_mismatch("group number", got.gnum, want.gnum);
        if (got.gsize != want.gsize)   report_mismatch("group size", got.gsize, want.gsize);
        if (got.pindex != want.pindex) report_mismatch("parity index", got.pindex, want.pindex);
        if (got.pword != want.pword)   report_mismatch("parity word", got.pword, want.pword);
        if (got.pbytes != want.pbytes) report_mismatch("parity bytes", got.pbytes, want.pbytes);
        if (got.plast != want.plast)   report_mismatch("final word", got.plast, want.plast);
    endtask

    // Track every handshake: config, input items and parity words
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) grp_pkts_reg = i_cfg_data;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                fresh_words.delete();
                predict_parity_words(t_op'(i_s_axis_tuser), i_s_axis_tdata[63:0],
                                     i_s_axis_tdata[67:64], i_s_axis_tlast);
                if (row_typed) begin
                    if (row_has_word) parity_expected = {parity_expected, row_word};
                end else begin
                    parity_expected = {parity_expected, fresh_words};
                end
            end
            if (o_m_axis_tvalid && i_m_axis_tready) check_parity_word();
        end
    end

    // End the run when nothing has moved for too long
    always @(posedge i_clk) begin
        if ((i_cfg_valid && o_cfg_ready) || (i_s_axis_tvalid && o_s_axis_tready)
            || (o_m_axis_tvalid && i_m_axis_tready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: random stalls, open stretches and one long hold on request
    initial begin
        int r;
        int stall_left;
        int open_left;
        stall_left = 0;
        open_left  = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_m_axis_tready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else if (open_left > 0) begin
                open_left--;
                i_m_axis_tready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 6) open_left = $urandom_range(30, 100);
                else if (r < 25) stall_left = $urandom_range(1, 3);
                else if (r < 28) stall_left = $urandom_range(15, 50);
                i_m_axis_tready <= (stall_left == 0);
            end
        end
    end

    // Offer one item, hold it until taken, then maybe leave a gap
    task automatic send_item(input t_op op, input logic [63:0] data, input logic [3:0] nb,
                             input logic eop, input bit typed, input bit has_word,
                             input t_parity_word word);
        int r;
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'd0, nb, data};
        i_s_axis_tlast  <= eop;
        i_s_axis_tuser  <= op;
        row_typed       <= typed;
        row_has_word    <= has_word;
        row_word        <= word;
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            burst_left = $urandom_range(20, 60);
        end else if (r < 30) begin
            gap = (r < 27) ? $urandom_range(1, 3) : $urandom_range(10, 40);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_data(input logic [63:0] data, input logic [3:0] nb, input logic eop);
        send_item(OP_DATA, data, nb, eop, 1'b0, 1'b0, '0);
    endtask

    task automatic send_flush();
        send_item(OP_FLUSH, rand_word(), 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                  1'b0, 1'b0, '0);
    endtask

    // One packet of random words; may be cut short by a flush
    task automatic send_packet(input int n_words, input bit may_flush, inout int sent);
        logic [3:0] nb;
        for (int w = 0; w < n_words; w++) begin
            if (may_flush && w != n_words - 1 && $urandom_range(0, 99) < 2) begin
                send_flush();
                sent++;
                return;
            end
            if (w == n_words - 1 || $urandom_range(0, 99) < 20) nb = 4'($urandom_range(0, 15));
            else nb = 4'd8;
            send_data(rand_word(), nb, w == n_words - 1);
            sent++;
        end
    endtask

    task automatic random_traffic(input int n_items, input bit allow_long);
        int sent;
        int r;
        int n_words;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                send_flush();
                sent++;
            end else begin
                if (r < 60) n_words = $urandom_range(1, 3);
                else if (r < 90) n_words = $urandom_range(4, 10);
                else if (r < 97 || !allow_long) n_words = $urandom_range(11, 30);
                else n_words = $urandom_range(60, 70);
                send_packet(n_words, 1'b1, sent);
            end
        end
    endtask

    task automatic write_grp_pkts(input logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Stop offering, let every expected word drain, then let the block go quiet
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (parity_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int spare;
        spare = 0;
        directed_rows = '{
            // flush with nothing pending, then two empty packets
            '{OP_FLUSH, 64'h0, 4'd0, 1'b0, 1'b1, 1'b0, '0},
            '{OP_DATA, 64'h0123_4567_89AB_CDEF, 4'd0, 1'b1, 1'b1, 1'b0, '0},
            '{OP_DATA, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b1, 1'b1, 1'b1,
              '{16'd0, 8'd2, 8'd2, 64'h0, 4'd0, 1'b1}},
            // two packets of different lengths, oversized byte counts
            '{OP_DATA, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0, 1'b0, 1'b0, '0},
            '{OP_DATA, 64'h0123_4567_89AB_CDEF, 4'd3, 1'b1, 1'b0, 1'b0, '0},
            '{OP_DATA, 64'h0, 4'd9, 1'b0, 1'b0, 1'b0, '0},
            '{OP_DATA, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b0, 1'b0, 1'b0, '0},
            '{OP_DATA, 64'h0000_0000_0000_00A5, 4'd1, 1'b1, 1'b0, 1'b0, '0},
            // flush in the middle of a packet, then a flush with nothing pending
            '{OP_DATA, 64'hFEDC_BA98_7654_3210, 4'd5, 1'b1, 1'b0, 1'b0, '0},
            '{OP_DATA, 64'h5555_AAAA_5555_AAAA, 4'd2, 1'b0, 1'b0, 1'b0, '0},
            '{OP_FLUSH, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1, 1'b0, 1'b0, '0},
            '{OP_FLUSH, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1, 1'b1, 1'b0, '0},
            // final word with no valid bytes
            '{OP_DATA, 64'h8000_0000_0000_0001, 4'd12, 1'b0, 1'b0, 1'b0, '0},
            '{OP_DATA, 64'hC3C3_C3C3_C3C3_C3C3, 4'd0, 1'b1, 1'b0, 1'b0, '0},
            '{OP_DATA, 64'h7F7F_7F7F_7F7F_7F7F, 4'd7, 1'b1, 1'b0, 1'b0, '0},
            // one complete packet closed by a flush
            '{OP_DATA, 64'h3C3C_3C3C_3C3C_3C3C, 4'd4, 1'b0, 1'b0, 1'b0, '0},
            '{OP_DATA, 64'h9696_6969_9696_6969, 4'd6, 1'b0, 1'b0, 1'b0, '0},
            '{OP_DATA, 64'hDEAD_BEEF_CAFE_F00D, 4'd10, 1'b1, 1'b0, 1'b0, '0},
            '{OP_FLUSH, 64'h0, 4'd0, 1'b0, 1'b0, 1'b0, '0}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].op, directed_rows[i].data, directed_rows[i].nb,
                      directed_rows[i].eop, directed_rows[i].typed,
                      directed_rows[i].has_word, directed_rows[i].word);
        settle();

        // Hold the receiver off while the sender keeps going
        write_grp_pkts(8'd3);
        hold_request = 1'b1;
        random_traffic(35, 1'b0);
        settle();

        write_grp_pkts(8'd255);
        random_traffic(35, 1'b0);
        send_flush();
        settle();

        // Sizes below the minimum act as two; push past the end of the store
        write_grp_pkts(8'd0);
        random_traffic(10, 1'b1);
        send_packet(67, 1'b0, spare);
        send_packet(64, 1'b0, spare);
        settle();

        write_grp_pkts(8'd1);
        random_traffic(25, 1'b1);
        settle();

        // Lower the size with packets already pending
        write_grp_pkts(8'd6);
        repeat (4) send_packet($urandom_range(1, 4), 1'b0, spare);
        settle();
        write_grp_pkts(8'd2);
        send_packet(2, 1'b0, spare);
        settle();

        repeat (3) begin
            write_grp_pkts(8'($urandom_range(2, 12)));
            random_traffic(20, 1'b1);
            send_flush();
            settle();
        end

        write_grp_pkts(8'd4);
        random_traffic(20, 1'b0);
        send_flush();
        settle();

        if (mismatch_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

/* xor_parity_fec_encoder_top.f */
rtl/xpf_pkg.sv
rtl/xpf_store.sv
rtl/xpf_emit.sv
rtl/xor_parity_fec_encoder_top.sv
bench/testbench.sv
